// ===== hw/rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console cursor engine: field
// widths, command and control-character codes, register indexes and the
// decode record passed from the cursor logic to the top level.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Field widths fixed by the command and result formats.
    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CODE_W = 7;
    localparam int OFS_W  = 19;
    localparam int LEFT_W = 10;
    localparam int TOP_W  = 9;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Command opcodes.
    typedef enum logic [0:0] {
        OP_PUT   = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    // Control characters acted on by a put.
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    // Tab stops fall on multiples of this many columns.
    localparam logic [COL_W:0] TAB_STEP = 7'd8;
    localparam logic [COL_W:0] TAB_MASK = 7'h78;

    // Register indexes (word address paddr[4:2]).
    typedef enum logic [2:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_TOP    = 3'd1,
        REG_WIN_RIGHT  = 3'd2,
        REG_WIN_BOTTOM = 3'd3,
        REG_TEXT_COLS  = 3'd4,
        REG_TEXT_ROWS  = 3'd5
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [LEFT_W-1:0] RST_WIN_LEFT   = 10'd48;
    localparam logic [TOP_W-1:0]  RST_WIN_TOP    = 9'd48;
    localparam logic [LEFT_W-1:0] RST_WIN_RIGHT  = 10'd592;
    localparam logic [TOP_W-1:0]  RST_WIN_BOTTOM = 9'd432;
    localparam logic [COL_W-1:0]  RST_TEXT_COLS  = 6'd45;
    localparam logic [ROW_W-1:0]  RST_TEXT_ROWS  = 5'd16;

    // What one command does, as seen by the rest of the pipeline.
    typedef struct packed {
        logic              draw;
        logic [CODE_W-1:0] code;
        logic              scroll;
        logic              clear;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  pos_col;
        logic [ROW_W-1:0]  pos_row;
    } t_step;

endpackage

// ===== hw/rtl/tcce_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tcce_cmd_if
// Command channel: one put or clear command per transfer.
// ----------------------------------------------------------------------------
interface tcce_cmd_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [0:0]        opcode;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, opcode, char_code, input ready);
    modport sink   (input valid, opcode, char_code, output ready);

endinterface

// ===== hw/rtl/tcce_res_if.sv =====
// ----------------------------------------------------------------------------
// tcce_res_if
// Result channel: draw, scroll and clear requests plus the new cursor.
// ----------------------------------------------------------------------------
interface tcce_res_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic              draw_glyph;
    logic [CODE_W-1:0] glyph_code;
    logic [OFS_W-1:0]  draw_offset;
    logic              scroll_up;
    logic              clear_window;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;

    modport source (output valid, draw_glyph, glyph_code, draw_offset, scroll_up,
                    clear_window, cursor_col, cursor_row, input ready);
    modport sink   (input valid, draw_glyph, glyph_code, draw_offset, scroll_up,
                    clear_window, cursor_col, cursor_row, output ready);

endinterface

// ===== hw/rtl/tcce_cursor.sv =====
// ----------------------------------------------------------------------------
// tcce_cursor
// Next-cursor logic for one command: control characters, printable glyphs,
// line wrap and scroll clamp. Purely combinational; the caller holds the
// cursor registers.
// ----------------------------------------------------------------------------
module tcce_cursor (
    input  logic [0:0]                  i_opcode,
    input  logic [tcce_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcce_pkg::COL_W-1:0]  i_col,
    input  logic [tcce_pkg::ROW_W-1:0]  i_row,
    input  logic [tcce_pkg::COL_W-1:0]  i_text_columns,
    input  logic [tcce_pkg::ROW_W-1:0]  i_text_rows,
    output tcce_pkg::t_step             o_step
);
    import tcce_pkg::*;

    // One extra column bit and two extra row bits hold the values that
    // overflow before the wrap and clamp checks.
    logic [COL_W:0]   col;
    logic [ROW_W+1:0] row;
    logic [ROW_W-1:0] rows;

    always_comb begin
        o_step  = '0;
        col     = {1'b0, i_col};
        row     = {2'b0, i_row};
        rows    = (i_text_rows == '0) ? ROW_W'(1) : i_text_rows;
        o_step.pos_col = i_col;
        o_step.pos_row = i_row;

        if (i_opcode == OP_CLEAR) begin
            // Clear homes the cursor; the fill starts at the window corner.
            col = '0;
            row = '0;
            o_step.clear   = 1'b1;
            o_step.pos_col = '0;
            o_step.pos_row = '0;
        end else begin
            case (i_char_code)
                CH_BS: begin
                    if (col != '0) begin
                        col = col - 1'b1;
                    end
                end
                CH_TAB: begin
                    col = (col + TAB_STEP) & TAB_MASK;
                end
                CH_CR: begin
                    col = '0;
                end
                CH_LF: begin
                    col = '0;
                    row = row + 1'b1;
                end
                default: begin
                    if (i_char_code inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                        o_step.draw = 1'b1;
                        o_step.code = i_char_code[CODE_W-1:0];
                        col = col + 1'b1;
                    end
                end
            endcase

            // Wrap past the last column onto the next line.
            if (col >= {1'b0, i_text_columns}) begin
                col = '0;
                row = row + 1'b1;
            end

            // Past the last line: scroll and stay on the last line.
            if (row >= {2'b0, rows}) begin
                o_step.scroll = 1'b1;
                row = {2'b0, rows - 1'b1};
            end
        end

        o_step.col = col[COL_W-1:0];
        o_step.row = row[ROW_W-1:0];
    end

endmodule

// ===== hw/rtl/text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Each result passes through three register stages. Throughput: one
// command per cycle unless a refused result stalls the pipeline; the cursor
// register loop through the next-cursor logic is the only feedback path,
// so commands run back to back. The offset multiplies sit in the two
// stages after that loop.
// Reset: synchronous active-low i_rst_n empties the pipeline, homes the
// cursor and loads the register defaults.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
    parameter int SCREEN_WIDTH = 640,
    parameter int GLYPH_WIDTH  = 12,
    parameter int GLYPH_HEIGHT = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcce_cmd_if.sink                    i_cmd,
    tcce_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcce_pkg::ADDR_W-1:0] paddr,
    input  logic [tcce_pkg::DATA_W-1:0] pwdata,
    output logic [tcce_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import tcce_pkg::*;

    // Configuration registers.
    logic [LEFT_W-1:0] r_win_left;
    logic [TOP_W-1:0]  r_win_top;
    logic [LEFT_W-1:0] r_win_right;
    logic [TOP_W-1:0]  r_win_bottom;
    logic [COL_W-1:0]  r_text_cols;
    logic [ROW_W-1:0]  r_text_rows;

    // Cursor state.
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    // Pipeline stages.
    logic              r_v1, r_v2, r_v3;
    t_step             r_step1, r_step2, r_step3;
    logic [OFS_W-1:0]  r_xpix2, r_ypix2;
    logic [OFS_W-1:0]  r_offset3;

    t_step             n_step;
    logic [OFS_W-1:0]  n_offset;
    logic              advance;
    logic              cmd_xfer;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign reg_idx  = paddr[ADDR_W-1:2];

    // Stall the whole pipeline only while a finished result is refused.
    assign advance     = !r_v3 || o_res.ready;
    assign i_cmd.ready = advance;
    assign cmd_xfer    = i_cmd.valid & advance;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= RST_WIN_LEFT;
            r_win_top    <= RST_WIN_TOP;
            r_win_right  <= RST_WIN_RIGHT;
            r_win_bottom <= RST_WIN_BOTTOM;
            r_text_cols  <= RST_TEXT_COLS;
            r_text_rows  <= RST_TEXT_ROWS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WIN_LEFT:   r_win_left   <= pwdata[LEFT_W-1:0];
                REG_WIN_TOP:    r_win_top    <= pwdata[TOP_W-1:0];
                REG_WIN_RIGHT:  r_win_right  <= pwdata[LEFT_W-1:0];
                REG_WIN_BOTTOM: r_win_bottom <= pwdata[TOP_W-1:0];
                REG_TEXT_COLS:  r_text_cols  <= pwdata[COL_W-1:0];
                REG_TEXT_ROWS:  r_text_rows  <= pwdata[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            REG_WIN_LEFT:   prdata = DATA_W'(r_win_left);
            REG_WIN_TOP:    prdata = DATA_W'(r_win_top);
            REG_WIN_RIGHT:  prdata = DATA_W'(r_win_right);
            REG_WIN_BOTTOM: prdata = DATA_W'(r_win_bottom);
            REG_TEXT_COLS:  prdata = DATA_W'(r_text_cols);
            REG_TEXT_ROWS:  prdata = DATA_W'(r_text_rows);
            default:        prdata = '0;
        endcase
    end

    // Next cursor for the command on the input channel.
    tcce_cursor u_cursor (
        .i_opcode       (i_cmd.opcode),
        .i_char_code    (i_cmd.char_code),
        .i_col          (r_col),
        .i_row          (r_row),
        .i_text_columns (r_text_cols),
        .i_text_rows    (r_text_rows),
        .o_step         (n_step)
    );

    // Control: cursor state and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else if (advance) begin
            if (cmd_xfer) begin
                r_col <= n_step.col;
                r_row <= n_step.row;
            end
            r_v1 <= cmd_xfer;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Offset is taken modulo 2^19, so every product is kept at that width.
    assign n_offset = r_xpix2 + r_ypix2 * OFS_W'(SCREEN_WIDTH);

    // Payload stages: pixel coordinates, then the frame-buffer word offset.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_step1   <= n_step;
            r_step2   <= r_step1;
            r_xpix2   <= OFS_W'(r_step1.pos_col) * OFS_W'(GLYPH_WIDTH)
                         + OFS_W'(r_win_left);
            r_ypix2   <= OFS_W'(r_step1.pos_row) * OFS_W'(GLYPH_HEIGHT)
                         + OFS_W'(r_win_top);
            r_step3   <= r_step2;
            r_offset3 <= (r_step2.draw || r_step2.clear) ? n_offset : '0;
        end
    end

    // Result channel.
    assign o_res.valid        = r_v3;
    assign o_res.draw_glyph   = r_step3.draw;
    assign o_res.glyph_code   = r_step3.code;
    assign o_res.draw_offset  = r_offset3;
    assign o_res.scroll_up    = r_step3.scroll;
    assign o_res.clear_window = r_step3.clear;
    assign o_res.cursor_col   = r_step3.col;
    assign o_res.cursor_row   = r_step3.row;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor engine. A cursor tracker
// follows every accepted command, predicts the draw, scroll and clear
// requests and the new cursor, and compares each result transfer field by
// field. The run goes through directed commands, then random command streams
// under several window settings, with random gaps on the command side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import tcce_pkg::*;

    localparam int SCREEN_W      = 640;
    localparam int GLYPH_W       = 12;
    localparam int GLYPH_H       = 24;
    localparam int SETTLE_CYCLES = 8;

    // One expected or observed result.
    typedef struct {
        logic              draw;
        logic [CODE_W-1:0] code;
        logic [OFS_W-1:0]  ofs;
        logic              scroll;
        logic              clear;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_cursor_move;

    // Tracks the cursor and window registers and holds the outstanding moves.
    class cursor_tracker;
        int           win_left, win_top, win_right, win_bottom;
        int           text_cols, text_rows;
        int           column, line;
        int           errors;
        t_cursor_move expected_moves[$];

        function new();
            win_left   = RST_WIN_LEFT;
            win_top    = RST_WIN_TOP;
            win_right  = RST_WIN_RIGHT;
            win_bottom = RST_WIN_BOTTOM;
            text_cols  = RST_TEXT_COLS;
            text_rows  = RST_TEXT_ROWS;
            column     = 0;
            line       = 0;
            errors     = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_WIN_LEFT:   win_left   = value[LEFT_W-1:0];
                REG_WIN_TOP:    win_top    = value[TOP_W-1:0];
                REG_WIN_RIGHT:  win_right  = value[LEFT_W-1:0];
                REG_WIN_BOTTOM: win_bottom = value[TOP_W-1:0];
                REG_TEXT_COLS:  text_cols  = value[COL_W-1:0];
                REG_TEXT_ROWS:  text_rows  = value[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the effect of one accepted command and queue it.
        function void note_command(t_opcode op, logic [CHAR_W-1:0] ch);
            t_cursor_move m;
            int           c, r, rows, ofs_full;
            m = '{draw: 1'b0, code: '0, ofs: '0, scroll: 1'b0, clear: 1'b0,
                  col: '0, row: '0};
            c = column;
            r = line;
            if (op == OP_CLEAR) begin
                c        = 0;
                r        = 0;
                m.clear  = 1'b1;
                ofs_full = win_left + win_top * SCREEN_W;
                m.ofs    = ofs_full[OFS_W-1:0];
            end else begin
                // A window of zero rows acts as a single row.
                rows = (text_rows == 0) ? 1 : text_rows;
                case (ch)
                    CH_BS:  if (c != 0) c = c - 1;
                    CH_TAB: c = (c + 8) & ~7;
                    CH_CR:  c = 0;
                    CH_LF: begin
                        c = 0;
                        r = r + 1;
                    end
                    default: begin
                        // Printable bytes draw at the cursor before it moves.
                        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                            m.draw   = 1'b1;
                            m.code   = ch[CODE_W-1:0];
                            ofs_full = c * GLYPH_W + win_left +
                                       (r * GLYPH_H + win_top) * SCREEN_W;
                            m.ofs    = ofs_full[OFS_W-1:0];
                            c        = c + 1;
                        end
                    end
                endcase
                // Wrap and scroll checks run for every put, ignored bytes too.
                if (c >= text_cols) begin
                    c = 0;
                    r = r + 1;
                end
                if (r >= rows) begin
                    m.scroll = 1'b1;
                    r        = rows - 1;
                end
            end
            column = c % 64;
            line   = r % 32;
            m.col  = column[COL_W-1:0];
            m.row  = line[ROW_W-1:0];
            expected_moves.push_back(m);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_cursor_move got);
            t_cursor_move want;
            if (expected_moves.size() == 0) begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            want = expected_moves.pop_front();
            compare_field("draw_glyph",   32'(want.draw),   32'(got.draw));
            compare_field("glyph_code",   32'(want.code),   32'(got.code));
            compare_field("draw_offset",  32'(want.ofs),    32'(got.ofs));
            compare_field("scroll_up",    32'(want.scroll), 32'(got.scroll));
            compare_field("clear_window", 32'(want.clear),  32'(got.clear));
            compare_field("cursor_col",   32'(want.col),    32'(got.col));
            compare_field("cursor_row",   32'(want.row),    32'(got.row));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit            gaps_on;
    bit            stalls_on;
    cursor_tracker tracker;
    t_cursor_move  observed;

    tcce_cmd_if cmd ();
    tcce_res_if res ();

    text_console_cursor_engine_unit #(
        .SCREEN_WIDTH (SCREEN_W),
        .GLYPH_WIDTH  (GLYPH_W),
        .GLYPH_HEIGHT (GLYPH_H)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: ready with random stall bursts.
    initial begin
        int stall;
        stall     = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                res.ready <= 1'b0;
                stall--;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                res.ready <= 1'b0;
                stall = $urandom_range(0, 11);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // Check every result transfer against the oldest expected move.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            observed.draw   = res.draw_glyph;
            observed.code   = res.glyph_code;
            observed.ofs    = res.draw_offset;
            observed.scroll = res.scroll_up;
            observed.clear  = res.clear_window;
            observed.col    = res.cursor_col;
            observed.row    = res.cursor_row;
            tracker.check_result(observed);
        end
    end

    // Register write: setup cycle, then access cycle until pready. The bus
    // stays selected so that writes can follow one another directly.
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(idx, value);
        @(negedge i_clk);
    endtask

    // Write all six window registers, sometimes with junk above the field.
    task automatic apply_window(int left, int top, int right, int bottom,
                                int cols, int rows);
        logic [DATA_W-1:0] junk;
        junk = $urandom_range(0, 1) ? ($urandom << 10) : '0;
        write_reg(REG_WIN_LEFT,   junk | left);
        write_reg(REG_WIN_TOP,    junk | top);
        write_reg(REG_WIN_RIGHT,  junk | right);
        write_reg(REG_WIN_BOTTOM, junk | bottom);
        write_reg(REG_TEXT_COLS,  junk | cols);
        write_reg(REG_TEXT_ROWS,  junk | rows);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One command transfer, optionally preceded by an idle gap.
    task automatic send_command(t_opcode op, logic [CHAR_W-1:0] ch);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd.valid     <= 1'b1;
        cmd.opcode    <= op;
        cmd.char_code <= ch;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
        tracker.note_command(op, ch);
        @(negedge i_clk);
    endtask

    // Mostly text with controls mixed in, rare clears, some raw bytes.
    task automatic run_random(int count);
        t_opcode           op;
        logic [CHAR_W-1:0] ch;
        int                roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            op   = OP_PUT;
            if (roll < 2) begin
                op = OP_CLEAR;
                ch = CHAR_W'($urandom);
            end else if (roll < 50) begin
                ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
            end else if (roll < 58) begin
                ch = CH_BS;
            end else if (roll < 66) begin
                ch = CH_TAB;
            end else if (roll < 72) begin
                ch = CH_CR;
            end else if (roll < 82) begin
                ch = CH_LF;
            end else if (roll < 90) begin
                ch = CHAR_W'($urandom_range(0, CH_PRINT_LO - 1));
            end else begin
                ch = CHAR_W'($urandom);
            end
            send_command(op, ch);
        end
    endtask

    // Let every expected result arrive, then let the pipeline settle.
    task automatic finish_phase();
        cmd.valid <= 1'b0;
        while (tracker.expected_moves.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Main sequence.
    initial begin
        tracker       = new();
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd.valid     = 1'b0;
        cmd.opcode    = OP_PUT;
        cmd.char_code = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands under the reset window.
        send_command(OP_CLEAR, 8'hFF);
        send_command(OP_PUT, CH_BS);
        send_command(OP_PUT, CH_PRINT_LO);
        send_command(OP_PUT, CH_PRINT_HI);
        send_command(OP_PUT, 8'h41);
        send_command(OP_PUT, CH_BS);
        send_command(OP_PUT, CH_TAB);
        send_command(OP_PUT, CH_TAB);
        send_command(OP_PUT, 8'h00);
        send_command(OP_PUT, 8'h1F);
        send_command(OP_PUT, 8'h80);
        send_command(OP_PUT, 8'hFF);
        send_command(OP_PUT, 8'h0B);
        send_command(OP_PUT, CH_CR);
        send_command(OP_PUT, CH_LF);
        send_command(OP_PUT, 8'h55);
        send_command(OP_CLEAR, 8'h00);
        send_command(OP_PUT, 8'h2A);
        send_command(OP_PUT, 8'h1B);
        finish_phase();

        // Largest register values: the offset wraps past its width.
        apply_window(1023, 511, 1023, 511, 63, 31);
        run_random(110);
        finish_phase();

        // Zero columns and rows, with a stale cursor from the phase before.
        apply_window(0, 0, 0, 0, 0, 0);
        run_random(60);
        finish_phase();

        // Top of the documented ranges.
        apply_window(639, 479, 640, 480, 53, 20);
        run_random(110);
        finish_phase();

        // Single-cell window: every printable wraps and scrolls.
        apply_window(0, 0, 1, 1, 1, 1);
        run_random(80);
        finish_phase();

        // Random windows, alternating small text areas and full-width values.
        for (int k = 0; k < 6; k++) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (k % 2 == 0) begin
                apply_window($urandom_range(0, 639), $urandom_range(0, 479),
                             $urandom_range(1, 640), $urandom_range(1, 480),
                             $urandom_range(2, 12), $urandom_range(2, 5));
            end else begin
                apply_window($urandom_range(0, 1023), $urandom_range(0, 511),
                             $urandom_range(0, 1023), $urandom_range(0, 511),
                             $urandom_range(0, 63), $urandom_range(0, 31));
            end
            run_random(110);
            finish_phase();
        end

        // Closing stretch at full rate on both sides.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        apply_window(48, 48, 592, 432, $urandom_range(8, 53), $urandom_range(2, 20));
        run_random(120);
        finish_phase();

        if (tracker.errors == 0 && tracker.expected_moves.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_cmd_if.sv
hw/rtl/tcce_res_if.sv
hw/rtl/tcce_cursor.sv
hw/rtl/text_console_cursor_engine_unit.sv
tb/tb_top.sv
